// ===== design/ibf_pkg.sv =====
package ibf_pkg;

   localparam int DEFAULT_MAX_BURST_BYTES = 32768;

   localparam int BYTE_W    = 8;
   localparam int LEN_W     = 15;
   localparam int WORD_W    = 16;
   localparam int STATUS_W  = 2;
   localparam int BURST_W   = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 16;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;

   localparam int MAX_RESULTS = 7;
   localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
   localparam int HOLD_BYTES  = 6;

   localparam logic [WORD_W-1:0]  PA_WORD     = 16'hF872;
   localparam logic [WORD_W-1:0]  PB_WORD     = 16'h4E1F;
   localparam logic [2:0]         BSMOD_MASK  = 3'h7;
   localparam logic [LEN_W:0]     HEADER_BYTES = 16'd8;
   localparam logic [WORD_W-1:0]  HEADER_WORDS = 16'd4;

   localparam logic [BYTE_W-1:0]  RST_DATA_TYPE   = 8'd1;
   localparam logic [BURST_W-1:0] RST_BURST_BYTES = 16'd6144;
   localparam logic               RST_AC3_MODE    = 1'b1;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_PAD  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_DATA_TYPE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BURST_BYTES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AC3_MODE    = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_WORD = 2'd0,
      ST_DROP = 2'd1,
      ST_BUSY = 2'd2
   } status_type;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      status_type        status;
      logic              last;
   } result_type;

endpackage

// ===== design/iec61937_burst_framer.sv =====
// IEC 61937 burst framer.
// req channel: one beat per frame byte or pad tick. req_tuser is the operation
// (0 frame byte, 1 pad tick); req_tdata carries the byte and the frame length,
// which is sampled on the first byte of each frame.
// rsp channel: one beat per burst word or status report. rsp_tuser is the
// status (0 word, 1 frame dropped oversize, 2 byte rejected busy), rsp_tlast
// marks the final word of a burst.
// csr port: write-only, data type code, burst size in bytes, AC3 mode.
// Each req beat is decoded in the cycle it is taken and its results are
// loaded into a seven-entry result buffer; the first result shows on rsp in the
// cycle after the req beat. While rsp_tready is high, a beat that yields at
// most one result leaves req_tready high, so bytes stream at one per cycle.
// The sixth byte of a frame (or the last byte of a short frame) yields the
// four preamble words plus up to three payload words; req then holds until
// only the last of them is pending.
// Beats that yield no result leave req_tready high.
// When rsp_tready is low the front result holds and req_tready stays low
// while any result is pending.
// Reset clears the frame state, empties the buffer and restores the register
// defaults (type 1, 6144 bytes, AC3 mode on).
module iec61937_burst_framer
   import ibf_pkg::*;
#(
   parameter int MAX_BURST_BYTES = DEFAULT_MAX_BURST_BYTES
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [REQ_DATA_W-1:0]   req_tdata,   // data_byte[7:0], frame_length[22:8]
   input  logic                    req_tuser,   // operation[0]
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RSP_DATA_W-1:0]   rsp_tdata,   // sample_word[15:0]
   output logic [STATUS_W-1:0]     rsp_tuser,   // status[1:0]
   output logic                    rsp_tlast,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_W-1:0]        csr_wdata
);

   localparam int PAD_W = $clog2(MAX_BURST_BYTES / 2);
   localparam logic [BURST_W:0] MAX_BURST = (BURST_W + 1)'(MAX_BURST_BYTES);

   logic [BYTE_W-1:0]  dtype_ff;
   logic [BURST_W-1:0] burst_ff;
   logic               ac3_ff;

   logic [LEN_W-1:0]   pos_ff, pos_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [PAD_W-1:0]   pad_ff, pad_in;
   logic               drop_ff, drop_in;
   logic [BYTE_W-1:0]  held_ff [HOLD_BYTES];
   logic [BYTE_W-1:0]  held_in [HOLD_BYTES];
   logic [BYTE_W-1:0]  merged  [HOLD_BYTES];

   result_type         buf_ff [MAX_RESULTS];
   result_type         res    [MAX_RESULTS];
   logic [RES_CNT_W-1:0] cnt_ff, res_cnt;

   logic [BYTE_W-1:0]  req_byte;
   logic [LEN_W-1:0]   req_length;
   logic               accept, pop;
   logic               first, oversize, last_byte, pos_lt6;
   logic [2:0]         pos_lo, bsmod;
   logic [LEN_W-1:0]   cur_len;
   logic [LEN_W:0]     pos_next;
   logic [WORD_W-1:0]  total, used, pad_full;
   logic [PAD_W-1:0]   pad_new;

   assign req_byte   = req_tdata[BYTE_W-1:0];
   assign req_length = req_tdata[BYTE_W+LEN_W-1:BYTE_W];

   assign rsp_tvalid = (cnt_ff != '0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign req_tready = (cnt_ff == '0) || (cnt_ff == RES_CNT_W'(1) && rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign rsp_tdata = buf_ff[0].word;
   assign rsp_tuser = buf_ff[0].status;
   assign rsp_tlast = buf_ff[0].last;

   assign first     = (pos_ff == '0);
   assign cur_len   = first ? req_length : len_ff;
   assign oversize  = (req_length == '0)
                   || (({1'b0, req_length} + HEADER_BYTES) > {1'b0, burst_ff})
                   || ({1'b0, burst_ff} > MAX_BURST);
   assign pos_next  = {1'b0, pos_ff} + (LEN_W + 1)'(1);
   assign last_byte = (pos_next == {1'b0, cur_len});
   assign pos_lt6   = (pos_ff < LEN_W'(HOLD_BYTES));
   assign pos_lo    = pos_ff[2:0];
   assign bsmod     = (ac3_ff && cur_len >= LEN_W'(HOLD_BYTES)) ? (req_byte[2:0] & BSMOD_MASK)
                                                                 : 3'd0;

   assign total    = {1'b0, burst_ff[BURST_W-1:1]};
   assign used     = HEADER_WORDS + WORD_W'(({1'b0, cur_len} + (LEN_W + 1)'(1)) >> 1);
   assign pad_full = (total > used) ? (total - used) : '0;
   assign pad_new  = pad_full[PAD_W-1:0];

   always_comb begin
      for (int i = 0; i < HOLD_BYTES; i++) begin
         merged[i] = (pos_lt6 && pos_lo == 3'(i)) ? req_byte : held_ff[i];
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         res[i] = '{word: '0, status: ST_WORD, last: 1'b0};
      end
      res_cnt = '0;
      pos_in  = pos_ff;
      len_in  = len_ff;
      pad_in  = pad_ff;
      drop_in = drop_ff;
      for (int i = 0; i < HOLD_BYTES; i++) begin
         held_in[i] = held_ff[i];
      end

      if (req_tuser == OP_PAD) begin
         if (pad_ff != '0) begin
            res[0].last = (pad_ff == PAD_W'(1));
            res_cnt     = RES_CNT_W'(1);
            pad_in      = pad_ff - PAD_W'(1);
         end
      end else if (pad_ff != '0) begin
         res[0].status = ST_BUSY;
         res_cnt       = RES_CNT_W'(1);
      end else if (first && oversize) begin
         res[0].status = ST_DROP;
         res_cnt       = RES_CNT_W'(1);
         len_in        = req_length;
         drop_in       = (req_length > LEN_W'(1));
         pos_in        = (req_length > LEN_W'(1)) ? LEN_W'(1) : '0;
      end else if (!first && drop_ff) begin
         if (pos_next >= {1'b0, len_ff}) begin
            pos_in  = '0;
            drop_in = 1'b0;
         end else begin
            pos_in = pos_next[LEN_W-1:0];
         end
      end else begin
         len_in  = cur_len;
         drop_in = 1'b0;
         if (pos_lt6) begin
            for (int i = 0; i < HOLD_BYTES; i++) begin
               held_in[i] = merged[i];
            end
            if (pos_lo == 3'd5 || last_byte) begin
               res[0].word = PA_WORD;
               res[1].word = PB_WORD;
               res[2].word = {5'd0, bsmod, dtype_ff};
               res[3].word = {cur_len[12:0], 3'd0};
               for (int j = 0; j < 3; j++) begin
                  if (3'(2 * j + 1) <= pos_lo) begin
                     res[4 + j].word = {merged[2 * j], merged[2 * j + 1]};
                  end else begin
                     res[4 + j].word = {8'd0, merged[2 * j]};
                  end
               end
               res_cnt = RES_CNT_W'(5) + RES_CNT_W'(pos_lo >> 1);
            end
         end else if (!pos_ff[0]) begin
            held_in[0] = req_byte;
            if (last_byte) begin
               res[0].word = {8'd0, req_byte};
               res_cnt     = RES_CNT_W'(1);
            end
         end else begin
            res[0].word = {held_ff[0], req_byte};
            res_cnt     = RES_CNT_W'(1);
         end

         if (last_byte) begin
            pad_in = pad_new;
            pos_in = '0;
            if (pad_new == '0 && res_cnt != '0) begin
               for (int i = 0; i < MAX_RESULTS; i++) begin
                  if (RES_CNT_W'(i + 1) == res_cnt) begin
                     res[i].last = 1'b1;
                  end
               end
            end
         end else begin
            pos_in = pos_next[LEN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dtype_ff <= RST_DATA_TYPE;
         burst_ff <= RST_BURST_BYTES;
         ac3_ff   <= RST_AC3_MODE;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DATA_TYPE:   dtype_ff <= csr_wdata[BYTE_W-1:0];
            CSR_BURST_BYTES: burst_ff <= csr_wdata[BURST_W-1:0];
            CSR_AC3_MODE:    ac3_ff   <= csr_wdata[0];
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         len_ff  <= '0;
         pad_ff  <= '0;
         drop_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         if (accept) begin
            pos_ff  <= pos_in;
            len_ff  <= len_in;
            pad_ff  <= pad_in;
            drop_ff <= drop_in;
            cnt_ff  <= res_cnt;
         end else if (pop) begin
            cnt_ff <= cnt_ff - RES_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < HOLD_BYTES; i++) begin
            held_ff[i] <= held_in[i];
         end
         for (int i = 0; i < MAX_RESULTS; i++) begin
            buf_ff[i] <= res[i];
         end
      end else if (pop) begin
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            buf_ff[i] <= buf_ff[i + 1];
         end
      end
   end

endmodule

// ===== design/ibf_checker.sv =====
module ibf_checker
   import ibf_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,  // sample_word[15:0]
   input logic [STATUS_W-1:0]   rsp_tuser,  // status[1:0]
   input logic                  rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

   a_status_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_WORD |-> rsp_tdata == '0 && !rsp_tlast
                                             && (rsp_tuser == ST_DROP
                                                 || rsp_tuser == ST_BUSY))
      else $error("status beat carries data or last flag");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req stalled with empty result buffer");

endmodule

bind iec61937_burst_framer ibf_checker u_ibf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import ibf_pkg::*;

   localparam int          CYCLE_LIMIT = 1_200_000;
   localparam int          MAX_BURST   = 32768;
   localparam logic [15:0] SYNC_A      = 16'hF872;
   localparam logic [15:0] SYNC_B      = 16'h4E1F;

   typedef struct packed {
      logic        regs;
      logic [7:0]  code;
      logic [15:0] bytes;
      logic        ac3;
      logic        op;
      logic [7:0]  data;
      logic [14:0] flen;
      logic        typed;
      result_type  want;
   } script_row_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = OP_BYTE;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = CSR_DATA_TYPE;
   logic [CSR_W-1:0]      csr_wdata  = '0;

   logic [7:0]  reg_type   = 8'd1;
   logic [15:0] reg_burst  = 16'd6144;
   logic        reg_ac3    = 1'b1;
   logic [14:0] frame_pos  = '0;
   logic [14:0] frame_len  = '0;
   logic [7:0]  held [6]   = '{default: 8'h00};
   logic [13:0] pads_owed  = '0;
   logic        swallowing = 1'b0;

   result_type     beat_words [$];
   result_type     words_due [$];
   script_row_type script [$];
   int             beats_sent = 0;
   int             mismatches = 0;
   int             cycles     = 0;
   bit             steady     = 1'b0;

   iec61937_burst_framer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic result_type word_beat(input logic [15:0] w, input status_type s,
                                            input logic l);
      result_type r;
      r.word   = w;
      r.status = s;
      r.last   = l;
      return r;
   endfunction

   function automatic bit hold_off();
      return !steady && ($urandom_range(0, 99) < 30);
   endfunction

   // Burst words caused by one beat; updates the framer state.
   function automatic void burst_words_for(input logic op, input logic [7:0] data,
                                           input logic [14:0] flen);
      int          pos;
      int          len;
      int          total;
      int          used;
      int          k;
      logic        at_end;
      logic [15:0] pc;
      beat_words = {};
      if (op == OP_PAD) begin
         if (pads_owed != 0) begin
            pads_owed = pads_owed - 1'b1;
            beat_words.push_back(word_beat(16'h0000, ST_WORD, pads_owed == 0));
         end
         return;
      end
      if (pads_owed != 0) begin
         beat_words.push_back(word_beat(16'h0000, ST_BUSY, 1'b0));
         return;
      end
      if (frame_pos == 0) begin
         frame_len  = flen;
         swallowing = 1'b0;
         if (flen == 0 || int'(flen) + 8 > int'(reg_burst) || int'(reg_burst) > MAX_BURST) begin
            if (flen > 1) begin
               swallowing = 1'b1;
               frame_pos  = 15'd1;
            end
            beat_words.push_back(word_beat(16'h0000, ST_DROP, 1'b0));
            return;
         end
      end
      if (swallowing) begin
         frame_pos = frame_pos + 1'b1;
         if (frame_pos >= frame_len) begin
            frame_pos  = '0;
            swallowing = 1'b0;
         end
         return;
      end
      pos    = frame_pos;
      len    = frame_len;
      at_end = (pos + 1 == len);
      if (pos < 6) begin
         held[pos] = data;
         if (pos == 5 || at_end) begin
            pc = {8'h00, reg_type};
            if (reg_ac3 && len >= 6) pc[10:8] = held[5][2:0];
            beat_words.push_back(word_beat(SYNC_A, ST_WORD, 1'b0));
            beat_words.push_back(word_beat(SYNC_B, ST_WORD, 1'b0));
            beat_words.push_back(word_beat(pc, ST_WORD, 1'b0));
            beat_words.push_back(word_beat({frame_len[12:0], 3'b000}, ST_WORD, 1'b0));
            for (k = 0; k <= pos; k += 2) begin
               if (k + 1 <= pos)
                  beat_words.push_back(word_beat({held[k], held[k+1]}, ST_WORD, 1'b0));
               else
                  beat_words.push_back(word_beat({8'h00, held[k]}, ST_WORD, 1'b0));
            end
         end
      end else if (pos % 2 == 0) begin
         held[0] = data;
         if (at_end) beat_words.push_back(word_beat({8'h00, data}, ST_WORD, 1'b0));
      end else begin
         beat_words.push_back(word_beat({held[0], data}, ST_WORD, 1'b0));
      end
      if (at_end) begin
         total     = int'(reg_burst) / 2;
         used      = 4 + (len + 1) / 2;
         pads_owed = (total > used) ? 14'(total - used) : 14'd0;
         if (pads_owed == 0 && beat_words.size() > 0)
            beat_words[beat_words.size()-1].last = 1'b1;
         frame_pos = '0;
      end else begin
         frame_pos = frame_pos + 1'b1;
      end
   endfunction

   function automatic script_row_type row_beat(input logic op, input logic [7:0] data,
                                               input logic [14:0] flen);
      script_row_type r;
      r      = '0;
      r.op   = op;
      r.data = data;
      r.flen = flen;
      return r;
   endfunction

   function automatic script_row_type row_typed(input logic op, input logic [7:0] data,
                                                input logic [14:0] flen, input status_type s,
                                                input logic l);
      script_row_type r;
      r       = row_beat(op, data, flen);
      r.typed = 1'b1;
      r.want  = word_beat(16'h0000, s, l);
      return r;
   endfunction

   function automatic script_row_type row_regs(input logic [7:0] code,
                                               input logic [15:0] bytes, input logic ac3);
      script_row_type r;
      r       = '0;
      r.regs  = 1'b1;
      r.code  = code;
      r.bytes = bytes;
      r.ac3   = ac3;
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 100) $display("mismatch at cycle %0d: %s", cycles, what);
   endtask

   // hold the beat until taken, then queue its burst words
   task automatic send_beat(input logic op, input logic [7:0] data, input logic [14:0] flen,
                            input logic typed = 1'b0, input result_type want = '0);
      while (hold_off()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {1'b0, flen, data};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_words_for(op, data, flen);
      if (typed)
         words_due.push_back(want);
      else
         foreach (beat_words[i]) words_due.push_back(beat_words[i]);
      if (beat_words.size() != 0 || op == OP_BYTE) beats_sent++;
   endtask

   task automatic send_frame(input int len);
      int i;
      send_beat(OP_BYTE, 8'($urandom), 15'(len));
      for (i = 1; i < len; i++) send_beat(OP_BYTE, 8'($urandom), 15'($urandom));
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (words_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_registers(input logic [7:0] code, input logic [15:0] bytes,
                                input logic ac3);
      csr_we    <= 1'b1;
      csr_index <= CSR_DATA_TYPE;
      csr_wdata <= {8'h00, code};
      @(posedge clock);
      csr_index <= CSR_BURST_BYTES;
      csr_wdata <= bytes;
      @(posedge clock);
      csr_index <= CSR_AC3_MODE;
      csr_wdata <= {15'h0000, ac3};
      @(posedge clock);
      csr_we    <= 1'b0;
      reg_type  = code;
      reg_burst = bytes;
      reg_ac3   = ac3;
   endtask

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      result_type due;
      rsp_tready <= !hold_off();
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (words_due.size() == 0) begin
            report_mismatch($sformatf("unexpected beat %h/%0d/%b",
                                      rsp_tdata, rsp_tuser, rsp_tlast));
         end else begin
            due = words_due.pop_front();
            if (rsp_tdata !== due.word || rsp_tuser !== due.status || rsp_tlast !== due.last)
               report_mismatch($sformatf("got %h/%0d/%b want %h/%0d/%b",
                                         rsp_tdata, rsp_tuser, rsp_tlast,
                                         due.word, due.status, due.last));
         end
      end
   end

   initial begin
      int          phase;
      int          stop_at;
      int          phase_end;
      int          roll;
      int          len;
      int          pads;
      int          p;
      logic [15:0] bytes;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      script = '{
         row_beat (OP_PAD,  8'h00, 15'd0),
         row_typed(OP_BYTE, 8'hA5, 15'd0, ST_DROP, 1'b0),
         row_regs (8'h00, 16'd8, 1'b0),
         row_typed(OP_BYTE, 8'h00, 15'd2, ST_DROP, 1'b0),
         row_beat (OP_BYTE, 8'hFF, 15'h7FFF),
         row_typed(OP_BYTE, 8'h3C, 15'd1, ST_DROP, 1'b0),
         row_regs (8'hFF, 16'd12, 1'b1),
         row_beat (OP_BYTE, 8'h00, 15'd4),
         row_beat (OP_BYTE, 8'hFF, 15'd4),
         row_beat (OP_BYTE, 8'h12, 15'd4),
         row_beat (OP_BYTE, 8'h34, 15'd4),
         row_regs (8'h00, 16'd18, 1'b1),
         row_beat (OP_BYTE, 8'h01, 15'd7),
         row_beat (OP_BYTE, 8'h02, 15'd0),
         row_beat (OP_BYTE, 8'h03, 15'd0),
         row_beat (OP_BYTE, 8'h04, 15'd0),
         row_beat (OP_BYTE, 8'h05, 15'd0),
         row_beat (OP_BYTE, 8'hFF, 15'd0),
         row_beat (OP_BYTE, 8'h80, 15'd0),
         row_typed(OP_BYTE, 8'h55, 15'd7, ST_BUSY, 1'b0),
         row_typed(OP_PAD,  8'h00, 15'd0, ST_WORD, 1'b1),
         row_beat (OP_PAD,  8'h00, 15'd0),
         row_regs (8'h92, 16'd15, 1'b0),
         row_beat (OP_BYTE, 8'hC3, 15'd6),
         row_beat (OP_BYTE, 8'h5A, 15'd6),
         row_beat (OP_BYTE, 8'h7E, 15'd6),
         row_beat (OP_BYTE, 8'h81, 15'd6),
         row_beat (OP_BYTE, 8'h42, 15'd6),
         row_beat (OP_BYTE, 8'h07, 15'd6)
      };
      foreach (script[i]) begin
         if (script[i].regs) begin
            settle();
            set_registers(script[i].code, script[i].bytes, script[i].ac3);
         end else begin
            send_beat(script[i].op, script[i].data, script[i].flen,
                      script[i].typed, script[i].want);
         end
      end

      // burst sizes above the largest allowed
      settle();
      set_registers(8'($urandom), 16'h8001, 1'b1);
      send_frame(1);
      settle();
      set_registers(8'($urandom), 16'hFFFF, 1'b0);
      send_frame(3);

      stop_at = beats_sent + 435;
      for (phase = 0; beats_sent < stop_at; phase++) begin
         settle();
         bytes = 16'(2 * $urandom_range(5, 48) + ((phase % 4 == 3) ? 1 : 0));
         set_registers(8'($urandom), bytes, 1'($urandom));
         steady    = (phase == 2);
         phase_end = beats_sent + ((phase == 2) ? 120 : 60);
         while (beats_sent < phase_end) begin
            roll = $urandom_range(0, 99);
            if (roll < 4) settle();
            if (roll < 78) begin
               len = $urandom_range(1, int'(bytes) - 8);
               send_frame(len);
               pads = int'(bytes) / 2 - 4 - (len + 1) / 2;
               if (pads < 0) pads = 0;
               if ($urandom_range(0, 9) == 0) pads = $urandom_range(0, pads + 2);
               for (p = 0; p < pads; p++) begin
                  if ($urandom_range(0, 9) == 0)
                     send_beat(OP_BYTE, 8'($urandom), 15'($urandom));
                  send_beat(OP_PAD, 8'($urandom), 15'($urandom));
               end
            end else if (roll < 88) begin
               send_frame(int'(bytes) - 7 + $urandom_range(0, 20));
            end else if (roll < 93) begin
               send_beat(OP_BYTE, 8'($urandom), 15'd0);
            end else begin
               send_beat(OP_PAD, 8'($urandom), 15'($urandom));
            end
         end
      end
      steady = 1'b0;

      settle();
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule

// ===== sim.f =====
design/ibf_pkg.sv
design/iec61937_burst_framer.sv
design/ibf_checker.sv
sim/testbench.sv
